// ===== design/shr_pkg.sv =====
package shr_pkg;

  localparam int KFRAC          = 16;
  localparam int K_HALF         = 1 << (KFRAC - 1);
  localparam int PHASE_INT_BITS = 5;
  localparam int MU_W           = 21;
  localparam int SQ_W           = 25;
  localparam int CU_W           = 29;
  localparam int COEF_W         = 32;
  localparam int COEF_STAGES    = 4;
  localparam int MAX_RESULTS    = 64;
  localparam int CNT_W          = $clog2(MAX_RESULTS);

  localparam logic [MU_W-1:0] MU_CLAMP = MU_W'(17 << KFRAC);

  typedef struct packed {
    logic signed [COEF_W-1:0] e0;
    logic signed [COEF_W-1:0] e1;
    logic signed [COEF_W-1:0] e2;
    logic signed [COEF_W-1:0] e3;
  } coef_t;

endpackage

// ===== design/shr_coef.sv =====
module shr_coef import shr_pkg::*; (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic [MU_W-1:0] mu_i,
  output coef_t           coef_o
);

  localparam int XW = COEF_W + 2;

  logic [MU_W-1:0]        mu_q [3];
  logic [SQ_W-1:0]        sq_q [2];
  logic [CU_W-1:0]        cu_q;
  coef_t                  coef_q;
  logic [2*MU_W-1:0]      sqp;
  logic [SQ_W+MU_W-1:0]   cup;
  logic signed [XW-1:0]   m1, m2, m3, t0, t1, t2, t3;
  coef_t                  coef_d;

  assign sqp = (2*MU_W)'(mu_q[0]) * (2*MU_W)'(mu_q[0]) + (2*MU_W)'(K_HALF);
  assign cup = (SQ_W+MU_W)'(sq_q[0]) * (SQ_W+MU_W)'(mu_q[1]) + (SQ_W+MU_W)'(K_HALF);

  // The factor one half of both slopes is folded in by doubling e0 and e3.
  always_comb begin
    m1 = XW'(mu_q[2]);
    m2 = XW'(sq_q[1]);
    m3 = XW'(cu_q);
    t0 = (m3 <<< 2) - (m2 <<< 2) - (m2 <<< 1) + (XW'(1) <<< (KFRAC + 1));
    t1 = m3 - (m2 <<< 1) + m1;
    t2 = m3 - m2;
    t3 = (m2 <<< 2) + (m2 <<< 1) - (m3 <<< 2);
    coef_d.e0 = t0[COEF_W-1:0];
    coef_d.e1 = t1[COEF_W-1:0];
    coef_d.e2 = t2[COEF_W-1:0];
    coef_d.e3 = t3[COEF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mu_q[0] <= mu_i;
      mu_q[1] <= mu_q[0];
      mu_q[2] <= mu_q[1];
      sq_q[0] <= sqp[KFRAC +: SQ_W];
      sq_q[1] <= sq_q[0];
      cu_q    <= cup[KFRAC +: CU_W];
      coef_q  <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== design/shr_lane.sv =====
module shr_lane import shr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_i [4],
  input  coef_t                         coef_i,
  output logic signed [SAMPLE_BITS-1:0] res_o
);

  localparam int DW  = SAMPLE_BITS + 1;
  localparam int PRW = COEF_W + DW;
  localparam int SW  = PRW + 1;
  localparam int AW  = PRW + 2;
  localparam int RW  = AW - (KFRAC + 1);
  localparam logic signed [RW-1:0] SMAX = RW'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [RW-1:0] SMIN = RW'(-(2**(SAMPLE_BITS-1)));

  logic signed [DW-1:0]  ax, bx, cx, dx;
  logic signed [DW-1:0]  b_q  [COEF_STAGES];
  logic signed [DW-1:0]  c_q  [COEF_STAGES];
  logic signed [DW-1:0]  ca_q [COEF_STAGES];
  logic signed [DW-1:0]  db_q [COEF_STAGES];
  logic signed [PRW-1:0] p_q  [4];
  logic signed [SW-1:0]  s_q  [2];
  logic signed [AW-1:0]  acc_q;
  logic signed [AW-1:0]  rnd;
  logic signed [AW-1:0]  shr;
  logic signed [RW-1:0]  rq;

  assign ax = DW'(hist_i[0]);
  assign bx = DW'(hist_i[1]);
  assign cx = DW'(hist_i[2]);
  assign dx = DW'(hist_i[3]);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_q[0]  <= bx;
      c_q[0]  <= cx;
      ca_q[0] <= cx - ax;
      db_q[0] <= dx - bx;
      for (int k = 1; k < COEF_STAGES; k++) begin
        b_q[k]  <= b_q[k-1];
        c_q[k]  <= c_q[k-1];
        ca_q[k] <= ca_q[k-1];
        db_q[k] <= db_q[k-1];
      end
      p_q[0] <= coef_i.e0 * b_q[COEF_STAGES-1];
      p_q[1] <= coef_i.e1 * ca_q[COEF_STAGES-1];
      p_q[2] <= coef_i.e2 * db_q[COEF_STAGES-1];
      p_q[3] <= coef_i.e3 * c_q[COEF_STAGES-1];
      s_q[0] <= SW'(p_q[0]) + SW'(p_q[1]);
      s_q[1] <= SW'(p_q[2]) + SW'(p_q[3]);
      acc_q  <= AW'(s_q[0]) + AW'(s_q[1]);
    end
  end

  always_comb begin
    rnd = acc_q + AW'(1 << KFRAC);
    shr = rnd >>> (KFRAC + 1);
    rq  = shr[RW-1:0];
    if (rq > SMAX) begin
      res_o = SMAX[SAMPLE_BITS-1:0];
    end else if (rq < SMIN) begin
      res_o = SMIN[SAMPLE_BITS-1:0];
    end else begin
      res_o = rq[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== design/stereo_hermite_resampler.sv =====
// Stereo cubic Hermite resampler.
// Input items are stereo frames on a valid/ready channel; output items are
// interpolated stereo frames with a flag on the last frame caused by an input.
// The phase step register, written through cfg_we_i and cfg_wdata_i, holds
// input samples per output sample in unsigned Q.24; the user must write it
// only while the block is idle, which the block itself does not enforce.
// An input item is taken while the sequencer is idle; the sequencer then
// issues one output step per cycle, holding while the receiver stalls, up
// to 64 steps, then accepts the next input item. Each step runs through a
// seven stage pipeline (mu, mu squared, mu cubed, kernel coefficients,
// products, two adder levels) and the output register.
// The two channels are computed by two identical lanes that share the
// coefficient pipeline; the output register merges their results.
// When the receiver stalls, the whole pipeline and the sequencer hold, and a
// new input item is still taken while results wait.
// Reset clears the history to zero and sets the phase and phase step to one.

module stereo_hermite_resampler import shr_pkg::*; #(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [PHASE_FRAC_BITS+PHASE_INT_BITS-1:0]    cfg_wdata_i,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]                left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]                right_in_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]                left_out_o,
  output logic signed [SAMPLE_BITS-1:0]                right_out_o,
  output logic                                         last_of_run_o
);

  localparam int PW          = PHASE_FRAC_BITS + PHASE_INT_BITS;
  localparam int PIPE_STAGES = COEF_STAGES + 3;
  localparam logic [PW-1:0]    PHASE_ONE = PW'(1) << PHASE_FRAC_BITS;
  localparam logic [PW-1:0]    PHASE_MAX = '1;
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic {IDLE, RUN} state_e;

  state_e                         state_q;
  logic [PW-1:0]                  phase_q;
  logic [PW-1:0]                  phase_step_q;
  logic [CNT_W-1:0]               cnt_q;
  logic signed [SAMPLE_BITS-1:0]  hist_l_q [4];
  logic signed [SAMPLE_BITS-1:0]  hist_r_q [4];

  logic                           adv;
  logic                           in_acc;
  logic [PW-1:0]                  phase_sub;
  logic [PW:0]                    step_sum;
  logic [PW-1:0]                  step_phase;
  logic [MU_W-1:0]                mu_raw;
  logic [MU_W-1:0]                step_mu;
  logic                           step_last;

  logic [PIPE_STAGES-1:0]         v_q;
  logic [PIPE_STAGES-1:0]         last_q;
  logic                           out_valid_q;
  logic                           out_last_q;
  logic signed [SAMPLE_BITS-1:0]  out_left_q;
  logic signed [SAMPLE_BITS-1:0]  out_right_q;
  logic signed [SAMPLE_BITS-1:0]  res_l;
  logic signed [SAMPLE_BITS-1:0]  res_r;
  coef_t                          coef;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    phase_sub  = (phase_q >= PHASE_ONE) ? (phase_q - PHASE_ONE) : '0;
    step_sum   = {1'b0, phase_q} + {1'b0, phase_step_q};
    step_phase = step_sum[PW] ? PHASE_MAX : step_sum[PW-1:0];
    mu_raw     = step_phase[PW-1 -: MU_W];
    step_mu    = (mu_raw > MU_CLAMP) ? MU_CLAMP : mu_raw;
    step_last  = (step_phase > PHASE_ONE) || (cnt_q == LAST_CNT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      phase_q      <= PHASE_ONE;
      phase_step_q <= PHASE_ONE;
      cnt_q        <= '0;
      for (int k = 0; k < 4; k++) begin
        hist_l_q[k] <= '0;
        hist_r_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        phase_step_q <= cfg_wdata_i;
      end
      unique case (state_q)
        IDLE: begin
          if (in_acc) begin
            phase_q <= phase_sub;
            cnt_q   <= '0;
            for (int k = 0; k < 3; k++) begin
              hist_l_q[k] <= hist_l_q[k+1];
              hist_r_q[k] <= hist_r_q[k+1];
            end
            hist_l_q[3] <= left_in_i;
            hist_r_q[3] <= right_in_i;
            if (phase_sub <= PHASE_ONE) begin
              state_q <= RUN;
            end
          end
        end
        RUN: begin
          if (adv) begin
            phase_q <= step_phase;
            cnt_q   <= cnt_q + 1'b1;
            if (step_last) begin
              state_q <= IDLE;
            end
          end
        end
      endcase
    end
  end

  shr_coef u_coef (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .mu_i   (step_mu),
    .coef_o (coef)
  );

  shr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_l (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .hist_i (hist_l_q),
    .coef_i (coef),
    .res_o  (res_l)
  );

  shr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_r (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .hist_i (hist_r_q),
    .coef_i (coef),
    .res_o  (res_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[PIPE_STAGES-2:0], (state_q == RUN)};
      out_valid_q <= v_q[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q      <= {last_q[PIPE_STAGES-2:0], step_last};
      out_last_q  <= last_q[PIPE_STAGES-1];
      out_left_q  <= res_l;
      out_right_q <= res_r;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = out_left_q;
  assign right_out_o   = out_right_q;
  assign last_of_run_o = out_last_q;

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RUN && adv && step_last) |=> (state_q == IDLE))
    else $error("Run did not end after its last step.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv) |=> $stable(v_q))
    else $error("Pipeline moved while the output was stalled.");

  a_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (phase_sub > PHASE_ONE)) |=> (state_q == IDLE))
    else $error("Steps started for an item that causes no result.");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

class hermite_scoreboard;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last_flag;
  } frame_t;

  localparam longint UNITY      = 64'sd1 << 24;
  localparam longint PHASE_MAX  = (64'sd1 << 29) - 1;
  localparam longint MU_LIMIT   = 64'sd17 << 16;
  localparam int     RESULT_CAP = 64;

  frame_t             expected_frames[$];
  logic signed [15:0] hist_left[4];
  logic signed [15:0] hist_right[4];
  longint             phase;
  longint             phase_step;
  int                 errors;
  int                 frames_in;
  int                 frames_out;
  int                 capped_runs;

  function new();
    for (int k = 0; k < 4; k++) begin
      hist_left[k]  = '0;
      hist_right[k] = '0;
    end
    phase       = UNITY;
    phase_step  = UNITY;
    errors      = 0;
    frames_in   = 0;
    frames_out  = 0;
    capped_runs = 0;
  endfunction

  function void set_step(longint value);
    phase_step = value & PHASE_MAX;
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction

  // Hermite kernel on four samples, oldest first, with mu in Q.16.
  function logic signed [15:0] hermite_point(longint mu, longint a, longint b,
                                             longint c, longint d);
    longint mu2, mu3, c0, c1, c2, c3, acc, r;
    mu2 = (mu * mu + 32768) >>> 16;
    mu3 = (mu2 * mu + 32768) >>> 16;
    c0  = 2 * mu3 - 3 * mu2 + 65536;
    c1  = mu3 - 2 * mu2 + mu;
    c2  = mu3 - mu2;
    c3  = -2 * mu3 + 3 * mu2;
    acc = 2 * c0 * b + c1 * (c - a) + c2 * (d - b) + 2 * c3 * c;
    r   = (acc + 65536) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function void note_frame(logic signed [15:0] left_in, logic signed [15:0] right_in);
    longint ph;
    longint mu;
    int     n;
    frame_t f;
    n  = 0;
    ph = (phase >= UNITY) ? phase - UNITY : 0;
    for (int k = 0; k < 3; k++) begin
      hist_left[k]  = hist_left[k+1];
      hist_right[k] = hist_right[k+1];
    end
    hist_left[3]  = left_in;
    hist_right[3] = right_in;
    while (ph <= UNITY && n < RESULT_CAP) begin
      ph = ph + phase_step;
      if (ph > PHASE_MAX) ph = PHASE_MAX;
      mu = ph >>> 8;
      if (mu > MU_LIMIT) mu = MU_LIMIT;
      f.left      = hermite_point(mu, hist_left[0], hist_left[1], hist_left[2], hist_left[3]);
      f.right     = hermite_point(mu, hist_right[0], hist_right[1], hist_right[2],
                                  hist_right[3]);
      f.last_flag = 1'b0;
      expected_frames.push_back(f);
      n++;
    end
    if (n > 0) expected_frames[expected_frames.size()-1].last_flag = 1'b1;
    if (n == RESULT_CAP) capped_runs++;
    phase = ph;
    frames_in++;
  endfunction

  function void check_frame(logic signed [15:0] left_out, logic signed [15:0] right_out,
                            logic last_of_run);
    frame_t e;
    frames_out++;
    if (expected_frames.size() == 0) begin
      $error("Output item arrived with nothing expected: left %0d right %0d last %0b",
             left_out, right_out, last_of_run);
      errors++;
      return;
    end
    e = expected_frames.pop_front();
    if (left_out !== e.left) begin
      $error("left_out: expected %0d, got %0d", e.left, left_out);
      errors++;
    end
    if (right_out !== e.right) begin
      $error("right_out: expected %0d, got %0d", e.right, right_out);
      errors++;
    end
    if (last_of_run !== e.last_flag) begin
      $error("last_of_run: expected %0b, got %0b", e.last_flag, last_of_run);
      errors++;
    end
  endfunction

endclass

module testbench;

  localparam int STEP_W        = 24 + shr_pkg::PHASE_INT_BITS;
  localparam int STEP_MIN      = 262145;
  localparam int STEP_MAX      = 268435456;
  localparam int STEP_UNITY    = 16777216;
  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_LIMIT    = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 35;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [STEP_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [15:0]       left_in_i   = '0;
  logic signed [15:0]       right_in_i  = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [15:0]       left_out_o;
  logic signed [15:0]       right_out_o;
  logic                     last_of_run_o;

  hermite_scoreboard sb;
  int                rx_mode     = 0;
  int                rx_hold     = 0;
  int                rx_tick     = 0;
  int                idle_cycles = 0;
  int                steps_used  = 0;
  bit                tx_gappy    = 1'b0;

  stereo_hermite_resampler #(
    .SAMPLE_BITS    (16),
    .PHASE_FRAC_BITS(24)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 2) != 0);
        2: out_ready_i <= ((rx_tick % 7) < 4);
        default: begin
          if ($urandom_range(0, 31) == 0) begin
            out_ready_i <= 1'b0;
            rx_hold     <= $urandom_range(5, 40);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_frame(left_out_o, right_out_o, last_of_run_o);
      if (in_valid_i && in_ready_o) sb.note_frame(left_in_i, right_in_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without an accepted item.", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
    in_valid_i <= 1'b1;
    left_in_i  <= left;
    right_in_i <= right;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= STEP_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_step(longint'(value));
    steps_used++;
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] prev);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return prev + 16'($urandom_range(0, 2047)) - 16'd1024;
    endcase
  endfunction

  task automatic random_frames(input int count);
    logic [15:0] left;
    logic [15:0] right;
    int          burst_left;
    left       = '0;
    right      = '0;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      left  = pick_sample(left);
      right = pick_sample(right);
      send_frame(left, right);
      burst_left--;
      if (burst_left == 0 && i != count - 1) begin
        burst_left = $urandom_range(1, 12);
        if (tx_gappy) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    int unsigned step;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_mode <= 1;

    // Reset step of one: every input after the first steps the phase from one to exactly two.
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'hFFFF, 16'h0001);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'h4000, 16'hC000);
    send_frame(16'h7FFF, 16'h8000);
    wait_drained();

    // Smallest step hits the cap of results per input.
    write_step(STEP_MIN);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h1234, 16'hEDCB);
    send_frame(16'h8000, 16'h7FFF);
    wait_drained();

    // Largest step leaves most inputs without output.
    write_step(STEP_MAX);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h5555, 16'hAAAA);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: step = STEP_MIN;
        1: step = STEP_MAX;
        2: step = STEP_UNITY;
        3: step = $urandom_range(STEP_MIN, STEP_MAX);
        4: step = $urandom_range(STEP_MIN, 2 * STEP_UNITY);
        default: step = $urandom_range(STEP_UNITY - (1 << 20), STEP_UNITY + (1 << 20));
      endcase
      write_step(step);
      rx_mode  <= $urandom_range(0, 3);
      tx_gappy = ($urandom_range(0, 2) != 0);
      random_frames(PHASE_ITEMS);
      wait_drained();
    end

    $display("Covered %0d input items, %0d output items, %0d step settings, %0d capped runs.",
             sb.frames_in, sb.frames_out, steps_used, sb.capped_runs);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== stereo_hermite_resampler.f =====
design/shr_pkg.sv
design/shr_coef.sv
design/shr_lane.sv
design/stereo_hermite_resampler.sv
bench/testbench.sv
